// ----- rtl/bcf_pkg.sv -----
// Shared types, constants and codes for the biquad cascade filter.
package bcf_pkg;

    localparam int MAX_SECTIONS = 8;
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 32;
    localparam int SLOTS        = 5;
    localparam int FRAC_SHIFT   = COEF_W - 4;
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W        = PROD_W + 3;
    localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int COEF_DEPTH   = MAX_SECTIONS * SLOTS;
    localparam int COEF_AW      = $clog2(COEF_DEPTH + 1);
    localparam int SLOT_W       = 3;
    localparam int NSEC_W       = 4;
    localparam int HROW_W       = 4 * SAMPLE_W;

    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    localparam logic REG_NUM_SECTIONS = 1'b0;
    localparam logic REG_OUTPUT_GAIN  = 1'b1;

    localparam logic signed [COEF_W-1:0] GAIN_RESET =
        {{3{1'b0}}, 1'b1, {(COEF_W-4){1'b0}}};

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_ACC,
        ST_ROUND,
        ST_GAIN,
        ST_GACC,
        ST_GOUT
    } state_t;

    typedef struct packed {
        logic acc_clr;
        logic mul_en;
        logic mul_sub;
        logic acc_add;
    } mac_ctrl_t;

endpackage

// ----- rtl/bcf_coef_mem.sv -----
// Coefficient memory: one write port, one registered read port.
module bcf_coef_mem (
    input  logic                              clk,
    input  logic                              we,
    input  logic [bcf_pkg::COEF_AW-1:0]       waddr,
    input  logic signed [bcf_pkg::COEF_W-1:0] wdata,
    input  logic                              re,
    input  logic [bcf_pkg::COEF_AW-1:0]       raddr,
    output logic signed [bcf_pkg::COEF_W-1:0] rdata
);
    import bcf_pkg::*;

    logic signed [COEF_W-1:0] mem [COEF_DEPTH];
    logic signed [COEF_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bcf_hist_mem.sv -----
// Section history memory: one row of {x1, x2, y1, y2} per section, row valid bits.
module bcf_hist_mem (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clr_all,
    input  logic                            we,
    input  logic [bcf_pkg::SEC_W-1:0]       waddr,
    input  logic [bcf_pkg::HROW_W-1:0]      wdata,
    input  logic                            re,
    input  logic [bcf_pkg::SEC_W-1:0]       raddr,
    output logic [bcf_pkg::HROW_W-1:0]      rdata
);
    import bcf_pkg::*;

    logic [HROW_W-1:0]       mem [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] row_ok_reg;
    logic [HROW_W-1:0]       q_reg;
    logic                    q_ok_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            q_ok_reg   <= 1'b0;
        end
        else
        begin
            if (clr_all)
            begin
                row_ok_reg <= '0;
            end
            else if (we)
            begin
                row_ok_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                q_ok_reg <= row_ok_reg[raddr];
            end
        end
    end

    // unwritten rows since reset or block start read as zero history
    assign rdata = q_ok_reg ? q_reg : '0;

endmodule

// ----- rtl/bcf_mac.sv -----
// Shared multiplier, accumulator and round/saturate stage.
module bcf_mac (
    input  logic                                clk,
    input  bcf_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [bcf_pkg::SAMPLE_W-1:0] op_a,
    input  logic signed [bcf_pkg::COEF_W-1:0]   op_b,
    output logic signed [bcf_pkg::SAMPLE_W-1:0] y,
    output logic                                clip
);
    import bcf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shifted;

    assign prod_next = op_a * op_b;
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_next = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
            sub_reg  <= ctrl.mul_sub;
        end
        acc_reg <= acc_next;
    end

    // round half up, floor shift, saturate to sample range
    assign rnd     = acc_reg + ROUND_HALF;
    assign shifted = rnd >>> FRAC_SHIFT;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            y    = SAT_HI[SAMPLE_W-1:0];
            clip = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            y    = SAT_LO[SAMPLE_W-1:0];
            clip = 1'b1;
        end
        else
        begin
            y    = shifted[SAMPLE_W-1:0];
            clip = 1'b0;
        end
    end

endmodule

// ----- rtl/biquad_cascade_filter.sv -----
// Biquad cascade filter top level: control sequencer, registers and result buffer.
//
// Requests arrive on req_valid/req_ready. A request with func = 1 writes one
// coefficient (b0, b1, b2, a1, a2 of one section, already scaled by 1/a0) and
// is written in the cycle it is taken, with no result. A request with func = 0 filters one
// Q1.23 sample through the first num_sections sections and the output gain;
// block_start clears all section history first.
// Each section runs on the single shared multiplier: ST_LOAD reads the history
// row and first coefficient, ST_MAC forms the five products, ST_ACC does the
// last accumulate and ST_ROUND rounds, saturates and writes back. The gain then
// runs through ST_GAIN, ST_GACC and ST_GOUT, where the result is registered; a
// new request is taken only in ST_IDLE, once the last one is through.
// The result sits in an output register on res_valid/res_ready. The next
// request is taken while it waits; if it is still not taken when the next
// result is ready, the sequencer holds until it is.
// Reset sets num_sections to 1, the gain to 1.0 and clears all history;
// coefficients are undefined until written.
module biquad_cascade_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [bcf_pkg::COEF_W-1:0]          cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                func,
    input  logic signed [bcf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                                block_start,
    input  logic [bcf_pkg::SEC_W-1:0]           coef_section,
    input  logic [bcf_pkg::SLOT_W-1:0]          coef_slot,
    input  logic signed [bcf_pkg::COEF_W-1:0]   coef_value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [bcf_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                saturated
);
    import bcf_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [SEC_W-1:0]          last_sec_reg;
    logic [SEC_W-1:0]          last_sec_next;
    logic signed [COEF_W-1:0]  gain_reg;
    logic [SEC_W-1:0]          sec_reg;
    logic [COEF_AW-1:0]        base_reg;
    logic [SLOT_W-1:0]         k_reg;
    logic signed [SAMPLE_W-1:0] w_reg;
    logic                      clip_reg;
    logic                      res_valid_reg;
    logic signed [SAMPLE_W-1:0] res_data_reg;
    logic                      res_clip_reg;

    logic                      accept;
    logic                      start_filter;
    logic                      res_free;

    mac_ctrl_t                 mac_ctrl;
    logic signed [SAMPLE_W-1:0] op_a;
    logic signed [COEF_W-1:0]  op_b;
    logic signed [SAMPLE_W-1:0] mac_y;
    logic                      mac_clip;

    logic                      coef_we;
    logic [COEF_AW-1:0]        coef_waddr;
    logic                      coef_re;
    logic [COEF_AW-1:0]        coef_raddr;
    logic signed [COEF_W-1:0]  coef_rdata;

    logic                      hist_clr;
    logic                      hist_we;
    logic                      hist_re;
    logic [HROW_W-1:0]         hist_wdata;
    logic [HROW_W-1:0]         hist_rdata;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;

    assign req_ready    = (state_reg == ST_IDLE);
    assign accept       = req_valid && req_ready;
    assign start_filter = accept && (func == FUNC_FILTER);
    assign res_free     = !res_valid_reg || res_ready;

    assign x1 = hist_rdata[4*SAMPLE_W-1:3*SAMPLE_W];
    assign x2 = hist_rdata[3*SAMPLE_W-1:2*SAMPLE_W];
    assign y1 = hist_rdata[2*SAMPLE_W-1:SAMPLE_W];
    assign y2 = hist_rdata[SAMPLE_W-1:0];

    // section count clamped to 1..MAX_SECTIONS, kept as last index
    always_comb
    begin
        if (cfg_data[NSEC_W-1:0] == '0)
        begin
            last_sec_next = '0;
        end
        else if (32'(cfg_data[NSEC_W-1:0]) > MAX_SECTIONS)
        begin
            last_sec_next = SEC_W'(MAX_SECTIONS - 1);
        end
        else
        begin
            last_sec_next = SEC_W'(cfg_data[NSEC_W-1:0] - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sec_reg <= '0;
            gain_reg     <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_SECTIONS: last_sec_reg <= last_sec_next;
                REG_OUTPUT_GAIN:  gain_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_filter)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_MAC;
            ST_MAC:
            begin
                if (k_reg == SLOT_A2)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:   state_next = ST_ROUND;
            ST_ROUND: state_next = (sec_reg == last_sec_reg) ? ST_GAIN : ST_LOAD;
            ST_GAIN:  state_next = ST_GACC;
            ST_GACC:  state_next = ST_GOUT;
            ST_GOUT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mac_ctrl   = '0;
        coef_we    = 1'b0;
        coef_re    = 1'b0;
        coef_raddr = base_reg;
        hist_clr   = 1'b0;
        hist_we    = 1'b0;
        hist_re    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                hist_clr = start_filter && block_start;
                coef_we  = accept && (func == FUNC_COEF) &&
                           (coef_slot inside {[SLOT_B0:SLOT_A2]});
            end
            ST_LOAD:
            begin
                hist_re          = 1'b1;
                coef_re          = 1'b1;
                mac_ctrl.acc_clr = 1'b1;
            end
            ST_MAC:
            begin
                mac_ctrl.mul_en  = 1'b1;
                mac_ctrl.mul_sub = (k_reg == SLOT_A1) || (k_reg == SLOT_A2);
                mac_ctrl.acc_add = (k_reg != SLOT_B0);
                coef_re          = (k_reg != SLOT_A2);
                coef_raddr       = base_reg + COEF_AW'(k_reg) + 1'b1;
            end
            ST_ACC:
            begin
                mac_ctrl.acc_add = 1'b1;
            end
            ST_ROUND:
            begin
                hist_we = 1'b1;
            end
            ST_GAIN:
            begin
                mac_ctrl.acc_clr = 1'b1;
                mac_ctrl.mul_en  = 1'b1;
            end
            ST_GACC:
            begin
                mac_ctrl.acc_add = 1'b1;
            end
            ST_GOUT:  ;
            default:  ;
        endcase
    end

    // sec * SLOTS + slot
    assign coef_waddr = COEF_AW'(coef_section) * COEF_AW'(SLOTS) + COEF_AW'(coef_slot);
    assign hist_wdata = {w_reg, x1, mac_y, y1};

    always_comb
    begin
        op_b = coef_rdata;
        op_a = w_reg;
        if (state_reg == ST_GAIN)
        begin
            op_b = gain_reg;
        end
        else
        begin
            case (k_reg)
                SLOT_B0: op_a = w_reg;
                SLOT_B1: op_a = x1;
                SLOT_B2: op_a = x2;
                SLOT_A1: op_a = y1;
                SLOT_A2: op_a = y2;
                default: op_a = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            sec_reg       <= '0;
            base_reg      <= '0;
            k_reg         <= SLOT_B0;
            clip_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_GOUT && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start_filter)
                    begin
                        sec_reg  <= '0;
                        base_reg <= '0;
                        clip_reg <= 1'b0;
                    end
                end
                ST_LOAD:  k_reg <= SLOT_B0;
                ST_MAC:   k_reg <= k_reg + 1'b1;
                ST_ROUND:
                begin
                    clip_reg <= clip_reg | mac_clip;
                    sec_reg  <= sec_reg + 1'b1;
                    base_reg <= base_reg + COEF_AW'(SLOTS);
                end
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_filter)
        begin
            w_reg <= sample_in;
        end
        else if (state_reg == ST_ROUND)
        begin
            w_reg <= mac_y;
        end
        if (state_reg == ST_GOUT && res_free)
        begin
            res_data_reg <= mac_y;
            res_clip_reg <= clip_reg | mac_clip;
        end
    end

    assign res_valid  = res_valid_reg;
    assign sample_out = res_data_reg;
    assign saturated  = res_clip_reg;

    bcf_coef_mem u_coef_mem (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bcf_hist_mem u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr_all (hist_clr),
        .we      (hist_we),
        .waddr   (sec_reg),
        .wdata   (hist_wdata),
        .re      (hist_re),
        .raddr   (sec_reg),
        .rdata   (hist_rdata)
    );

    bcf_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .y    (mac_y),
        .clip (mac_clip)
    );

endmodule
